// File: design/skvt_pkg.sv
// Shared command and status codes and the reserved key of the table.
`default_nettype none
package skvt_pkg;
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_FIND = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADKEY = 2'd2;
    localparam logic [1:0] ST_MISS   = 2'd3;

    localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

// File: design/skvt_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module skvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: design/sorted_key_value_table_unit.sv
// Top level of the sorted key/value table: sequencer around one table RAM.
// The table keeps up to CAPACITY-1 key/value pairs in ascending key order in a
// single-port RAM, and every memory access goes through that one port. A find is
// a binary search of at most log2(CAPACITY) steps, each one read and one compare.
// An add reads each entry with a larger key and writes it one place up, then
// writes the new pair; a delete finds its hit, then moves each entry above it
// down one place. A rejected add goes straight to its result. One item is in
// progress at a time; its result sits in an output register, and the next item
// is accepted once that result is taken, in the same cycle at the earliest.
`default_nettype none
module sorted_key_value_table_unit
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_found_value,
    output logic [7:0]       m_entry_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ARD   = 3'd1; // add: read entry below pos
    localparam logic [2:0] S_ACMP  = 3'd2; // add: compare and shift up
    localparam logic [2:0] S_SRD   = 3'd3; // search: read middle
    localparam logic [2:0] S_SCMP  = 3'd4; // search: compare
    localparam logic [2:0] S_DRD   = 3'd5; // delete: read entry above
    localparam logic [2:0] S_DWR   = 3'd6; // delete: write it down
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next, val_reg, val_next;
    logic [CW:0]   lo_reg, lo_next, hi_reg, hi_next; // signed-safe with offset
    logic [CW-1:0] pos_reg, pos_next;
    logic          mv_reg, mv_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   fv_reg, fv_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [63:0]   wdata, rdata;
    logic [CW:0]   mid;

    skvt_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // lo and hi carry +1 so that hi = -1 is represented as zero.
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign s_ready       = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign m_valid       = mv_reg;
    assign m_status      = st_reg;
    assign m_found_value = fv_reg;
    assign m_entry_count = 8'(fill_reg);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        mv_next    = mv_reg && !m_ready;
        st_next    = st_reg;
        fv_next    = fv_reg;
        we         = 1'b0;
        addr       = AW'(pos_reg);
        wdata      = {key_reg, val_reg};
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next = s_cmd;
                    key_next = s_key;
                    val_next = s_value;
                    pos_next = fill_reg;
                    lo_next  = (CW+1)'(1);
                    hi_next  = {1'b0, fill_reg};
                    fv_next  = '0;
                    st_next  = ST_MISS;
                    case (s_cmd)
                        CMD_ADD: begin
                            if (s_key == KEY_ALL_ONES) begin
                                st_next = ST_BADKEY;
                                state_next = S_DONE;
                            end else if (32'(fill_reg) + 32'd1 >= 32'(CAPACITY)) begin
                                st_next = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_ARD;
                            end
                        end
                        CMD_FIND, CMD_DEL: state_next = S_SRD;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_ARD: begin
                if (pos_reg == '0) begin
                    we = 1'b1;
                    addr = '0;
                    fill_next = fill_reg + 1'b1;
                    st_next = ST_OK;
                    state_next = S_DONE;
                end else begin
                    addr = AW'(pos_reg - 1'b1);
                    state_next = S_ACMP;
                end
            end
            S_ACMP: begin
                we = 1'b1;
                if (rdata[63:32] > key_reg) begin
                    wdata = rdata;
                    pos_next = pos_reg - 1'b1;
                    state_next = S_ARD;
                end else begin
                    fill_next = fill_reg + 1'b1;
                    st_next = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_SRD: begin
                if (lo_reg > hi_reg) begin
                    state_next = S_DONE;
                end else begin
                    addr = AW'(mid - 1'b1);
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                addr = AW'(mid - 1'b1);
                if (key_reg < rdata[63:32]) begin
                    hi_next = mid - 1'b1;
                    state_next = S_SRD;
                end else if (key_reg > rdata[63:32]) begin
                    lo_next = mid + 1'b1;
                    state_next = S_SRD;
                end else begin
                    fv_next = rdata[31:0];
                    st_next = ST_OK;
                    pos_next = CW'(mid - 1'b1);
                    if (cmd_reg == CMD_DEL) begin
                        state_next = S_DRD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DRD: begin
                if (pos_reg + 1'b1 >= fill_reg) begin
                    fill_next = fill_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    addr = AW'(pos_reg + 1'b1);
                    state_next = S_DWR;
                end
            end
            S_DWR: begin
                we = 1'b1;
                wdata = rdata;
                pos_next = pos_reg + 1'b1;
                state_next = S_DRD;
            end
            S_DONE: begin
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
        end
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        pos_reg <= pos_next;
        st_reg  <= st_next;
        fv_reg  <= fv_next;
    end
endmodule
`default_nettype wire

// File: design/skvt_checker.sv
// Port-level assertions for the sorted key/value table, bound to the top level.
`default_nettype none
module skvt_checker
    import skvt_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [31:0] m_found_value,
    input wire logic [7:0]  m_entry_count
);
    // A result that waits is held unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_value))
        else $error("result changed while stalled");

    // Only a successful request reports a value.
    a_fv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_found_value == 32'd0)
        else $error("value reported on failure");

    // No new item is taken in the cycle right after one was accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

    // A full rejection only comes from a table that holds entries.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_entry_count != 8'd0 || !m_valid)
        else $error("full reported with empty table");
endmodule

bind sorted_key_value_table_unit skvt_checker u_skvt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_found_value(m_found_value), .m_entry_count(m_entry_count)
);
`default_nettype wire

// File: test/tb.sv
// Testbench for the sorted key/value table: random and directed requests checked against a model.
`timescale 1ns / 100ps
module tb;
    import skvt_pkg::*;

    localparam int CAP = 256;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [31:0] s_key = '0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_found_value;
    logic [7:0]  m_entry_count;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [7:0]  entry_count;
    } reply_t;

    // Mirror of the table contents and the replies still owed by the block.
    logic [31:0] table_keys [CAP];
    logic [31:0] table_vals [CAP];
    int unsigned table_fill;
    reply_t      pending_replies[$];

    int errors = 0;
    int replies_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #6 aclk = ~aclk;

    sorted_key_value_table_unit #(.CAPACITY(CAP)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_key(s_key), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_found_value(m_found_value),
        .m_entry_count(m_entry_count)
    );

    function automatic int lookup_index(logic [31:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = int'(table_fill) - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (k < table_keys[mid]) hi = mid - 1;
            else if (k > table_keys[mid]) lo = mid + 1;
            else return mid;
        end
        return -1;
    endfunction

    function automatic reply_t apply_request(logic [1:0] cmd, logic [31:0] k,
                                             logic [31:0] v);
        reply_t r;
        int pos;
        int hit;
        r.status = ST_MISS;
        r.found_value = '0;
        if (cmd == CMD_ADD) begin
            if (k == KEY_ALL_ONES) begin
                r.status = ST_BADKEY;
            end else if (table_fill + 1 >= CAP) begin
                r.status = ST_FULL;
            end else begin
                pos = table_fill;
                while (pos > 0 && table_keys[pos-1] > k) begin
                    table_keys[pos] = table_keys[pos-1];
                    table_vals[pos] = table_vals[pos-1];
                    pos--;
                end
                table_keys[pos] = k;
                table_vals[pos] = v;
                table_fill++;
                r.status = ST_OK;
            end
        end else if (cmd == CMD_FIND || cmd == CMD_DEL) begin
            hit = lookup_index(k);
            if (hit >= 0) begin
                r.found_value = table_vals[hit];
                r.status = ST_OK;
                if (cmd == CMD_DEL) begin
                    for (int i = hit; i + 1 < int'(table_fill); i++) begin
                        table_keys[i] = table_keys[i+1];
                        table_vals[i] = table_vals[i+1];
                    end
                    table_fill--;
                end
            end
        end
        r.entry_count = table_fill[7:0];
        return r;
    endfunction

    // Valid stays high from one item to the next unless the sender idles.
    task automatic send_request(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_key   <= k;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_replies.push_back(apply_request(cmd, k, v));
    endtask

    // Receiver: random back-pressure and field checks against the oldest expectation.
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    $error("unexpected result: status %0d", m_status);
                    errors++;
                end else begin
                    exp_r = pending_replies.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, m_status);
                        errors++;
                    end
                    if (m_found_value !== exp_r.found_value) begin
                        $error("found_value: expected %h actual %h",
                               exp_r.found_value, m_found_value);
                        errors++;
                    end
                    if (m_entry_count !== exp_r.entry_count) begin
                        $error("entry_count: expected %0d actual %0d",
                               exp_r.entry_count, m_entry_count);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Picks a key that is often already held so finds and deletes hit.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (table_fill > 0 && sel < 5) return table_keys[$urandom_range(table_fill - 1)];
        if (sel == 5) return KEY_ALL_ONES;
        if (sel == 6) return $urandom_range(15);
        return $urandom;
    endfunction

    task automatic test_directed();
        send_request(CMD_FIND, 32'd5, 32'd0);
        send_request(CMD_DEL, 32'd5, 32'd0);
        send_request(CMD_ADD, KEY_ALL_ONES, 32'h1234);
        send_request(CMD_ADD, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_ADD, 32'hFFFF_FFFE, 32'h0);
        send_request(CMD_ADD, 32'd7, 32'hA);
        send_request(CMD_ADD, 32'd7, 32'hB);
        send_request(CMD_ADD, 32'd3, 32'hC);
        send_request(CMD_FIND, 32'd7, 32'hDEAD_BEEF);
        send_request(CMD_FIND, 32'd4, 32'h0);
        send_request(CMD_FIND, KEY_ALL_ONES, 32'h0);
        send_request(CMD_RSVD, 32'd7, 32'h5555_AAAA);
        send_request(CMD_DEL, 32'd7, 32'h0);
        send_request(CMD_DEL, 32'd0, 32'h0);
        send_request(CMD_FIND, 32'hFFFF_FFFE, 32'h0);
        send_request(CMD_DEL, 32'd8, 32'h0);
    endtask

    // Fills the table to its limit, probes the full case, then drains it.
    task automatic test_fill_and_drain();
        while (table_fill + 1 < CAP) send_request(CMD_ADD, $urandom, $urandom);
        send_request(CMD_ADD, 32'd1, 32'd1);
        send_request(CMD_ADD, KEY_ALL_ONES, 32'd1);
        send_request(CMD_FIND, table_keys[0], 32'd0);
        send_request(CMD_FIND, table_keys[table_fill-1], 32'd0);
        while (table_fill > 0)
            send_request(CMD_DEL, table_keys[$urandom_range(table_fill - 1)], $urandom);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [1:0] cmd;
        int sel;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 45) cmd = CMD_ADD;
            else if (sel < 75) cmd = CMD_FIND;
            else if (sel < 97) cmd = CMD_DEL;
            else cmd = CMD_RSVD;
            send_request(cmd, pick_key(), $urandom);
        end
    endtask

    initial begin
        table_fill = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(100, 0, 0);
        test_random(100, 68, 0);
        test_random(100, 0, 68);
        test_random(100, 24, 24);
        test_fill_and_drain();
        test_random(100, 0, 0);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Covered %0d results: directed edge cases, a full fill and drain,", replies_seen);
        $display("and random adds, finds and deletes under sender and receiver idling.");
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("simulation failed");
        $finish;
    end
endmodule

// File: filelist.f
design/skvt_pkg.sv
design/skvt_ram.sv
design/sorted_key_value_table_unit.sv
design/skvt_checker.sv
test/tb.sv
